FILE: rtl/nnds_pkg.sv
// Package for the nearest-neighbor BGRA downscaler.
// Holds the size limits, the alpha constant, the divider step count
// and the configuration register indexes used by the top level.
package nnds_pkg;

    // Field and register widths
    localparam int SRC_DIM_W = 16;
    localparam int DST_DIM_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COMP_W = 8;

    // Size limits applied to the effective frame sizes
    localparam logic [SRC_DIM_W-1:0] MAX_TARGET_DIM = 16'd4095;
    localparam logic [SRC_DIM_W-1:0] MAX_SOURCE_DIM = 16'd65535;

    // Alpha value used when input alpha is disabled
    localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // One quotient bit per divider step
    localparam int DIV_STEPS = SRC_DIM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_ALPHA_PRESENT = 3'd4
    } cfg_idx_t;

endpackage

FILE: rtl/nearest_neighbor_downscale_bgra_unit.sv
// Nearest-neighbor BGRA downscaler top level; depends on nnds_pkg.
// A sampled pixel appears on the master side in the cycle after its transfer.
// Throughput: one source pixel per cycle while the divider is idle; the output register
// frees in the cycle it is taken. After each register write the input stalls while the
// column and row step quotient and remainder are divided out, one bit per cycle.
// Reset: 1x1 source and target, alpha opaque, counters at zero, steps loaded directly.

module nearest_neighbor_downscale_bgra_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [nnds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnds_pkg::CFG_DATA_W-1:0] cfg_data,

    // Source pixels
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in

    // Output pixels
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // blue_out, green_out, red_out, alpha_out
    output logic        m_axis_tlast    // frame_end
);

    localparam int SW_W = nnds_pkg::SRC_DIM_W;
    localparam int DW_W = nnds_pkg::DST_DIM_W;
    localparam int CNT_W = nnds_pkg::DIV_CNT_W;

    // Configuration registers
    logic [SW_W-1:0] source_width_reg, source_width_next;
    logic [SW_W-1:0] source_height_reg, source_height_next;
    logic [DW_W-1:0] target_width_reg, target_width_next;
    logic [DW_W-1:0] target_height_reg, target_height_next;
    logic            alpha_present_reg, alpha_present_next;

    // Frame counters and sampling targets
    logic [SW_W-1:0] src_col_reg, src_col_next;
    logic [SW_W-1:0] src_row_reg, src_row_next;
    logic [DW_W-1:0] out_col_reg, out_col_next;
    logic [DW_W-1:0] out_row_reg, out_row_next;
    logic [SW_W-1:0] next_col_reg, next_col_next;
    logic [DW_W-1:0] col_rem_reg, col_rem_next;
    logic [SW_W-1:0] next_row_reg, next_row_next;
    logic [DW_W-1:0] row_rem_reg, row_rem_next;

    // Step quotient and remainder, and the shared divider control
    logic [SW_W-1:0] col_quo_reg, col_quo_next;
    logic [DW_W-1:0] col_div_rem_reg, col_div_rem_next;
    logic [SW_W-1:0] row_quo_reg, row_quo_next;
    logic [DW_W-1:0] row_div_rem_reg, row_div_rem_next;
    logic            div_start_reg, div_start_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;

    // Effective sizes
    logic [SW_W-1:0] sw_eff, sh_eff, tw_wide, th_wide;
    logic [DW_W-1:0] tw_eff, th_eff;

    logic            div_busy;
    logic            cfg_fire, in_fire, hit, last_col, last_row;
    logic [DW_W:0]   col_rem_sum, row_rem_sum;
    logic [DW_W:0]   col_trial, row_trial;
    logic            col_bit, row_bit;
    logic            cfg_hit;

    // Clamp a source size to 1..MAX_SOURCE_DIM
    function automatic logic [SW_W-1:0] clamp_src(input logic [SW_W-1:0] v);
        logic [SW_W-1:0] r;
        r = (v == '0) ? SW_W'(1) : v;
        if (r > nnds_pkg::MAX_SOURCE_DIM)
            r = nnds_pkg::MAX_SOURCE_DIM;
        return r;
    endfunction

    // Clamp a target size to 1..min(source, MAX_TARGET_DIM)
    function automatic logic [SW_W-1:0] clamp_dst(input logic [DW_W-1:0] v,
                                                  input logic [SW_W-1:0] src);
        logic [SW_W-1:0] r;
        r = (v == '0) ? SW_W'(1) : SW_W'(v);
        if (r > src)
            r = src;
        if (r > nnds_pkg::MAX_TARGET_DIM)
            r = nnds_pkg::MAX_TARGET_DIM;
        return r;
    endfunction

    always_comb
    begin
        sw_eff  = clamp_src(source_width_reg);
        sh_eff  = clamp_src(source_height_reg);
        tw_wide = clamp_dst(target_width_reg, sw_eff);
        th_wide = clamp_dst(target_height_reg, sh_eff);
        tw_eff  = tw_wide[DW_W-1:0];
        th_eff  = th_wide[DW_W-1:0];
    end

    // Handshakes
    assign div_busy      = div_start_reg || (div_cnt_reg != '0);
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s_axis_tready = !div_busy && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Sample decision for the current source position
    assign hit = (out_row_reg < th_eff) && (out_col_reg < tw_eff) &&
                 (src_row_reg == next_row_reg) && (src_col_reg == next_col_reg);
    assign last_col = (out_col_reg == tw_eff - DW_W'(1));
    assign last_row = (out_row_reg == th_eff - DW_W'(1));

    // Incremental remainder sums, below twice the target size
    assign col_rem_sum = {1'b0, col_rem_reg} + {1'b0, col_div_rem_reg};
    assign row_rem_sum = {1'b0, row_rem_reg} + {1'b0, row_div_rem_reg};

    // Restoring divider step: shift in the next dividend bit, try a subtract
    assign col_trial = {col_div_rem_reg, col_quo_reg[SW_W-1]};
    assign row_trial = {row_div_rem_reg, row_quo_reg[SW_W-1]};
    assign col_bit   = (col_trial >= {1'b0, tw_eff});
    assign row_bit   = (row_trial >= {1'b0, th_eff});

    always_comb
    begin
        source_width_next  = source_width_reg;
        source_height_next = source_height_reg;
        target_width_next  = target_width_reg;
        target_height_next = target_height_reg;
        alpha_present_next = alpha_present_reg;

        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        next_col_next = next_col_reg;
        col_rem_next  = col_rem_reg;
        next_row_next = next_row_reg;
        row_rem_next  = row_rem_reg;

        col_quo_next     = col_quo_reg;
        col_div_rem_next = col_div_rem_reg;
        row_quo_next     = row_quo_reg;
        row_div_rem_next = row_div_rem_reg;
        div_start_next   = 1'b0;
        div_cnt_next     = div_cnt_reg;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        cfg_hit        = 1'b0;

        // Drop the result once the master side takes it
        if (m_axis_tready)
            out_valid_next = 1'b0;

        // Run the step divider: load on start, then one bit per cycle
        if (div_start_reg)
        begin
            col_quo_next     = sw_eff;
            col_div_rem_next = '0;
            row_quo_next     = sh_eff;
            row_div_rem_next = '0;
            div_cnt_next     = CNT_W'(nnds_pkg::DIV_STEPS);
        end
        else if (div_cnt_reg != '0)
        begin
            col_quo_next     = {col_quo_reg[SW_W-2:0], col_bit};
            col_div_rem_next = col_bit ? DW_W'(col_trial - {1'b0, tw_eff})
                                       : col_trial[DW_W-1:0];
            row_quo_next     = {row_quo_reg[SW_W-2:0], row_bit};
            row_div_rem_next = row_bit ? DW_W'(row_trial - {1'b0, th_eff})
                                       : row_trial[DW_W-1:0];
            div_cnt_next     = div_cnt_reg - CNT_W'(1);
        end

        // Process one source pixel
        if (in_fire)
        begin
            out_valid_next = hit;
            out_data_next  = {alpha_present_reg ? s_axis_tdata[31:24]
                                                : nnds_pkg::ALPHA_OPAQUE,
                              s_axis_tdata[7:0],
                              s_axis_tdata[15:8],
                              s_axis_tdata[23:16]};
            out_last_next  = last_col && last_row;

            // Advance the sampling targets after an emitted pixel
            if (hit)
            begin
                if (last_col)
                begin
                    out_col_next  = '0;
                    next_col_next = '0;
                    col_rem_next  = '0;
                    out_row_next  = out_row_reg + DW_W'(1);
                    if (row_rem_sum >= {1'b0, th_eff})
                    begin
                        row_rem_next  = DW_W'(row_rem_sum - {1'b0, th_eff});
                        next_row_next = next_row_reg + row_quo_reg + SW_W'(1);
                    end
                    else
                    begin
                        row_rem_next  = row_rem_sum[DW_W-1:0];
                        next_row_next = next_row_reg + row_quo_reg;
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + DW_W'(1);
                    if (col_rem_sum >= {1'b0, tw_eff})
                    begin
                        col_rem_next  = DW_W'(col_rem_sum - {1'b0, tw_eff});
                        next_col_next = next_col_reg + col_quo_reg + SW_W'(1);
                    end
                    else
                    begin
                        col_rem_next  = col_rem_sum[DW_W-1:0];
                        next_col_next = next_col_reg + col_quo_reg;
                    end
                end
            end

            // Advance the source position, wrap at frame end
            if (src_col_reg >= sw_eff - SW_W'(1))
            begin
                src_col_next = '0;
                if (src_row_reg >= sh_eff - SW_W'(1))
                begin
                    src_row_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    next_col_next = '0;
                    col_rem_next  = '0;
                    next_row_next = '0;
                    row_rem_next  = '0;
                end
                else
                begin
                    src_row_next = src_row_reg + SW_W'(1);
                end
            end
            else
            begin
                src_col_next = src_col_reg + SW_W'(1);
            end
        end

        // Decode a configuration write
        if (cfg_fire)
        begin
            cfg_hit = 1'b1;
            unique case (nnds_pkg::cfg_idx_t'(cfg_index))
                nnds_pkg::CFG_SOURCE_WIDTH:  source_width_next  = cfg_data;
                nnds_pkg::CFG_SOURCE_HEIGHT: source_height_next = cfg_data;
                nnds_pkg::CFG_TARGET_WIDTH:  target_width_next  = cfg_data[DW_W-1:0];
                nnds_pkg::CFG_TARGET_HEIGHT: target_height_next = cfg_data[DW_W-1:0];
                nnds_pkg::CFG_ALPHA_PRESENT: alpha_present_next = cfg_data[0];
                default:                     cfg_hit = 1'b0;
            endcase
        end

        // Restart the frame and recompute the steps after a register write
        if (cfg_hit)
        begin
            src_col_next   = '0;
            src_row_next   = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            next_col_next  = '0;
            col_rem_next   = '0;
            next_row_next  = '0;
            row_rem_next   = '0;
            div_start_next = 1'b1;
            div_cnt_next   = '0;
        end
    end

    // Hold all state but the output payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= SW_W'(1);
            source_height_reg <= SW_W'(1);
            target_width_reg  <= DW_W'(1);
            target_height_reg <= DW_W'(1);
            alpha_present_reg <= 1'b0;
            src_col_reg       <= '0;
            src_row_reg       <= '0;
            out_col_reg       <= '0;
            out_row_reg       <= '0;
            next_col_reg      <= '0;
            col_rem_reg       <= '0;
            next_row_reg      <= '0;
            row_rem_reg       <= '0;
            col_quo_reg       <= SW_W'(1);
            col_div_rem_reg   <= '0;
            row_quo_reg       <= SW_W'(1);
            row_div_rem_reg   <= '0;
            div_start_reg     <= 1'b0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            source_width_reg  <= source_width_next;
            source_height_reg <= source_height_next;
            target_width_reg  <= target_width_next;
            target_height_reg <= target_height_next;
            alpha_present_reg <= alpha_present_next;
            src_col_reg       <= src_col_next;
            src_row_reg       <= src_row_next;
            out_col_reg       <= out_col_next;
            out_row_reg       <= out_row_next;
            next_col_reg      <= next_col_next;
            col_rem_reg       <= col_rem_next;
            next_row_reg      <= next_row_next;
            row_rem_reg       <= row_rem_next;
            col_quo_reg       <= col_quo_next;
            col_div_rem_reg   <= col_div_rem_next;
            row_quo_reg       <= row_quo_next;
            row_div_rem_reg   <= row_div_rem_next;
            div_start_reg     <= div_start_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // A register write stalls the input while the steps are recomputed
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index <= nnds_pkg::CFG_ALPHA_PRESENT) |=> !s_axis_tready)
        else $error("input accepted right after a configuration write");

    // The output column stays inside the target row
    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_col_reg < tw_eff)
        else $error("output column beyond target width");

    // Sampling remainders stay below their divisors
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_rem_reg < tw_eff) && (row_rem_reg < th_eff))
        else $error("sampling remainder out of range");

endmodule

FILE: verif/nearest_neighbor_downscale_bgra_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_neighbor_downscale_bgra_unit: a directed table,
// then random frames under random source and sink stalls, checked by a local predictor.
// Depends on nnds_pkg and the downscaler RTL.

module nearest_neighbor_downscale_bgra_unit_tb;

    localparam int unsigned TOTAL_PIXELS = 1750;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam longint RUN_LIMIT_NS = 10_000_000;
    localparam logic [nnds_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

    // Source pixel, red in the lowest byte
    typedef struct packed {
        logic [nnds_pkg::COMP_W-1:0] alpha;
        logic [nnds_pkg::COMP_W-1:0] blue;
        logic [nnds_pkg::COMP_W-1:0] green;
        logic [nnds_pkg::COMP_W-1:0] red;
    } rgba_t;

    // Output pixel, blue in the lowest byte
    typedef struct packed {
        logic [nnds_pkg::COMP_W-1:0] alpha;
        logic [nnds_pkg::COMP_W-1:0] red;
        logic [nnds_pkg::COMP_W-1:0] green;
        logic [nnds_pkg::COMP_W-1:0] blue;
    } bgra_t;

    typedef struct packed {
        logic  frame_end;
        bgra_t px;
    } out_item_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    // One row of the directed table; known marks a hand-written expectation
    typedef struct packed {
        row_kind_t                        kind;
        logic [nnds_pkg::CFG_IDX_W-1:0]   idx;
        logic [nnds_pkg::CFG_DATA_W-1:0]  data;
        rgba_t                            px;
        logic                             known;
        out_item_t                        known_res;
    } row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [nnds_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [nnds_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [31:0]                      s_axis_tdata;   // red, green, blue, alpha
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [31:0]                      m_axis_tdata;   // blue, green, red, alpha
    logic                             m_axis_tlast;   // frame_end

    // Hand-written expectation, driven alongside tdata
    logic                   known_valid;
    out_item_t              known_pixel;

    // Predictor copy of the registers and counters
    logic [nnds_pkg::SRC_DIM_W-1:0]   reg_src_w = 16'd1;
    logic [nnds_pkg::SRC_DIM_W-1:0]   reg_src_h = 16'd1;
    logic [nnds_pkg::DST_DIM_W-1:0]   reg_dst_w = 12'd1;
    logic [nnds_pkg::DST_DIM_W-1:0]   reg_dst_h = 12'd1;
    logic                             reg_alpha = 1'b0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   src_col = '0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   src_row = '0;
    logic [nnds_pkg::DST_DIM_W-1:0]   out_col = '0;
    logic [nnds_pkg::DST_DIM_W-1:0]   out_row = '0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   samp_col = '0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   col_rem = '0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   samp_row = '0;
    logic [nnds_pkg::SRC_DIM_W-1:0]   row_rem = '0;

    out_item_t              pending_q[$];
    int unsigned            mismatch_count = 0;
    int unsigned            pixels_sent = 0;
    bit                     src_gaps_on = 1'b1;
    bit                     sink_stall_on = 1'b1;
    bit                     hold_request = 1'b0;

    nearest_neighbor_downscale_bgra_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return all counters and sampling targets to the frame origin
    function automatic void restart_frame();
        src_col = '0;
        src_row = '0;
        out_col = '0;
        out_row = '0;
        samp_col = '0;
        col_rem = '0;
        samp_row = '0;
        row_rem = '0;
    endfunction

    // Register write; an unknown index leaves the frame running
    function automatic void apply_reg_write(input logic [nnds_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [nnds_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            nnds_pkg::CFG_SOURCE_WIDTH:  reg_src_w = val;
            nnds_pkg::CFG_SOURCE_HEIGHT: reg_src_h = val;
            nnds_pkg::CFG_TARGET_WIDTH:  reg_dst_w = val[nnds_pkg::DST_DIM_W-1:0];
            nnds_pkg::CFG_TARGET_HEIGHT: reg_dst_h = val[nnds_pkg::DST_DIM_W-1:0];
            nnds_pkg::CFG_ALPHA_PRESENT: reg_alpha = val[0];
            default:                     return;
        endcase
        restart_frame();
    endfunction

    // Advance the frame by one source pixel and report the output pixel it yields
    function automatic void scale_pixel(input rgba_t px, output bit hit, output out_item_t res);
        logic [nnds_pkg::SRC_DIM_W-1:0] sw;
        logic [nnds_pkg::SRC_DIM_W-1:0] sh;
        logic [nnds_pkg::SRC_DIM_W-1:0] tw;
        logic [nnds_pkg::SRC_DIM_W-1:0] th;
        logic                           last_col;
        longint unsigned                prod;
        sw = (reg_src_w == '0) ? 16'd1 : reg_src_w;
        sh = (reg_src_h == '0) ? 16'd1 : reg_src_h;
        tw = (reg_dst_w == '0) ? 16'd1 : {4'd0, reg_dst_w};
        th = (reg_dst_h == '0) ? 16'd1 : {4'd0, reg_dst_h};
        if (tw > sw) tw = sw;
        if (tw > nnds_pkg::MAX_TARGET_DIM) tw = nnds_pkg::MAX_TARGET_DIM;
        if (th > sh) th = sh;
        if (th > nnds_pkg::MAX_TARGET_DIM) th = nnds_pkg::MAX_TARGET_DIM;
        hit = 1'b0;
        res = '0;

        // Emit when the source position meets the next sampling target
        if (out_row < th && out_col < tw && src_row == samp_row && src_col == samp_col)
        begin
            last_col = (out_col == tw - 16'd1);
            hit = 1'b1;
            res.px.blue = px.blue;
            res.px.green = px.green;
            res.px.red = px.red;
            res.px.alpha = reg_alpha ? px.alpha : nnds_pkg::ALPHA_OPAQUE;
            res.frame_end = last_col && (out_row == th - 16'd1);
            if (last_col)
            begin
                out_col = '0;
                out_row = out_row + 12'd1;
                prod = out_row * sh;
                samp_row = 16'(prod / th);
                row_rem = 16'(prod % th);
            end
            else
            begin
                out_col = out_col + 12'd1;
            end
            prod = out_col * sw;
            samp_col = 16'(prod / tw);
            col_rem = 16'(prod % tw);
        end

        // Step the source raster, wrapping to a new frame after the last pixel
        if (src_col >= sw - 16'd1)
        begin
            src_col = '0;
            if (src_row >= sh - 16'd1)
                restart_frame();
            else
                src_row = src_row + 16'd1;
        end
        else
        begin
            src_col = src_col + 16'd1;
        end
    endfunction

    // Track register writes and source transfers, check output transfers
    always @(posedge clk)
    begin : scoreboard
        bit        hit;
        out_item_t res;
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                scale_pixel(s_axis_tdata, hit, res);
                if (known_valid)
                begin
                    hit = 1'b1;
                    res = known_pixel;
                end
                if (hit)
                    pending_q.push_back(res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tlast, m_axis_tdata};
                if (pending_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected output pixel %08h frame_end %0b",
                                 got.px, got.frame_end);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.px.blue != want.px.blue || got.px.green != want.px.green ||
                        got.px.red != want.px.red || got.px.alpha != want.px.alpha ||
                        got.frame_end != want.frame_end)
                    begin
                        if (mismatch_count < 10)
                            $display({"mismatch: expected b %02h g %02h r %02h a %02h end %0b,",
                                      " got b %02h g %02h r %02h a %02h end %0b"},
                                     want.px.blue, want.px.green, want.px.red,
                                     want.px.alpha, want.frame_end,
                                     got.px.blue, got.px.green, got.px.red,
                                     got.px.alpha, got.frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Sink readiness: random short and long stalls, plus one long hold-off on request
    initial
    begin : sink_ready
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_stall_on && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic row_t cfg_row(input logic [nnds_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [nnds_pkg::CFG_DATA_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = val;
        return r;
    endfunction

    function automatic row_t pix_row(input rgba_t px, input logic known, input out_item_t res);
        row_t r;
        r = '0;
        r.kind = ROW_PIX;
        r.px = px;
        r.known = known;
        r.known_res = res;
        return r;
    endfunction

    // Offer one source pixel and hold it until the transfer
    task automatic offer_pixel(input rgba_t px, input logic known, input out_item_t res);
        cfg_valid <= 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        known_valid <= known;
        known_pixel <= res;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // Drop valid for a random gap, mostly short
    task automatic sender_gap();
        int unsigned n;
        if (src_gaps_on && $urandom_range(0, 99) < 30)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random_pixels(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            offer_pixel($urandom(), 1'b0, '0);
            sender_gap();
        end
    endtask

    // Hold the source until every expected pixel is out, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [nnds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nnds_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_all_regs(input logic [15:0] sw, input logic [15:0] sh,
                                  input logic [15:0] tw, input logic [15:0] th,
                                  input logic [15:0] al);
        write_reg(nnds_pkg::CFG_SOURCE_WIDTH, sw);
        write_reg(nnds_pkg::CFG_SOURCE_HEIGHT, sh);
        write_reg(nnds_pkg::CFG_TARGET_WIDTH, tw);
        write_reg(nnds_pkg::CFG_TARGET_HEIGHT, th);
        write_reg(nnds_pkg::CFG_ALPHA_PRESENT, al);
    endtask

    initial
    begin : stimulus
        row_t        steps[$];
        bit          prev_pix;
        int unsigned phase;
        int unsigned n_pix;
        int unsigned split;
        logic [15:0] sw_v;
        logic [15:0] sh_v;
        logic [15:0] swe;
        logic [15:0] she;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        known_valid <= 1'b0;
        known_pixel <= '0;

        // Reset state is a 1x1 frame: every pixel comes out, marked as frame end
        steps.push_back(pix_row(32'h00000000, 1'b1, {1'b1, 32'hFF000000}));
        steps.push_back(pix_row(32'hFFFFFFFF, 1'b1, {1'b1, 32'hFFFFFFFF}));
        steps.push_back(pix_row(32'h78563412, 1'b1, {1'b1, 32'hFF123456}));
        // Pass input alpha through
        steps.push_back(cfg_row(nnds_pkg::CFG_ALPHA_PRESENT, 16'h0001));
        steps.push_back(pix_row(32'h78563412, 1'b1, {1'b1, 32'h78123456}));
        steps.push_back(pix_row(32'h00A5C33C, 1'b1, {1'b1, 32'h003CC3A5}));
        // Zero sizes act as one
        steps.push_back(cfg_row(nnds_pkg::CFG_SOURCE_WIDTH, 16'h0000));
        steps.push_back(cfg_row(nnds_pkg::CFG_TARGET_WIDTH, 16'h0000));
        steps.push_back(pix_row(32'h01020304, 1'b1, {1'b1, 32'h01040302}));
        // 5x3 source to 2 columns, height request above the source is clamped
        steps.push_back(cfg_row(nnds_pkg::CFG_SOURCE_WIDTH, 16'd5));
        steps.push_back(cfg_row(nnds_pkg::CFG_SOURCE_HEIGHT, 16'd3));
        steps.push_back(cfg_row(nnds_pkg::CFG_TARGET_WIDTH, 16'hF002));
        steps.push_back(cfg_row(nnds_pkg::CFG_TARGET_HEIGHT, 16'd9));
        steps.push_back(cfg_row(nnds_pkg::CFG_ALPHA_PRESENT, 16'hFFFE));
        for (int i = 0; i < 7; i++)
            steps.push_back(pix_row($urandom(), 1'b0, '0));
        // Unknown index mid-frame must not restart it
        steps.push_back(cfg_row(CFG_UNUSED_IDX, 16'hFFFF));
        // Finish the frame, then wrap into the next one
        for (int i = 0; i < 11; i++)
            steps.push_back(pix_row($urandom(), 1'b0, '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        prev_pix = 1'b0;
        foreach (steps[k])
        begin
            if (steps[k].kind == ROW_CFG)
            begin
                if (prev_pix)
                    wait_idle();
                write_reg(steps[k].idx, steps[k].data);
            end
            else
            begin
                offer_pixel(steps[k].px, steps[k].known, steps[k].known_res);
                sender_gap();
            end
            prev_pix = (steps[k].kind == ROW_PIX);
        end

        // Random phases, each with its own sizes and stall mix
        phase = 0;
        while (pixels_sent < TOTAL_PIXELS)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    // Largest source and target sizes
                    src_gaps_on = 1'b1;
                    sink_stall_on = 1'b1;
                    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
                    send_random_pixels(150);
                end
                1:
                begin
                    // Zero sizes everywhere, alpha forced opaque
                    write_all_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE);
                    send_random_pixels(30);
                end
                2:
                begin
                    // Every pixel sampled; sink holds off while the source keeps pushing
                    src_gaps_on = 1'b0;
                    sink_stall_on = 1'b0;
                    write_all_regs(16'd8, 16'd4, 16'd8, 16'd4, 16'($urandom_range(0, 1)));
                    hold_request = 1'b1;
                    send_random_pixels(64);
                end
                3:
                begin
                    // Widest source to a single pixel: one result, then frame done
                    src_gaps_on = 1'b1;
                    sink_stall_on = 1'b1;
                    write_all_regs(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'h0000);
                    send_random_pixels(40);
                end
                4:
                begin
                    // Tallest source: rows sampled roughly every sixteenth line
                    write_all_regs(16'd2, 16'hFFFF, 16'd2, 16'h0FFF, 16'h0001);
                    send_random_pixels(80);
                end
                default:
                begin
                    src_gaps_on = ($urandom_range(0, 3) != 0);
                    sink_stall_on = ($urandom_range(0, 3) != 0);
                    sw_v = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
                    sh_v = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
                    swe = (sw_v == '0) ? 16'd1 : sw_v;
                    she = (sh_v == '0) ? 16'd1 : sh_v;
                    write_all_regs(sw_v, sh_v,
                                   {4'($urandom_range(0, 15)), 12'($urandom_range(0, swe + 2))},
                                   {4'($urandom_range(0, 15)), 12'($urandom_range(0, she + 2))},
                                   {15'($urandom()), 1'($urandom_range(0, 1))});
                    n_pix = $urandom_range(1, 3) * swe * she + $urandom_range(0, swe);
                    if (n_pix > 1 && $urandom_range(0, 3) == 0)
                    begin
                        split = n_pix / 2;
                        send_random_pixels(split);
                        wait_idle();
                        write_reg(CFG_UNUSED_IDX, 16'($urandom()));
                        send_random_pixels(n_pix - split);
                    end
                    else
                    begin
                        send_random_pixels(n_pix);
                    end
                end
            endcase
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
